/* hw/rtl/cac_pkg.sv */
// Shared types and constants for the calorimeter attenuation correction block.
// No dependencies.
`default_nettype none

package cac_pkg;

	localparam int ENERGY_W = 16;
	localparam int FRAC_W   = 16;
	localparam int ATTEN_W  = 9;
	localparam int PROD_W   = 32;
	localparam int CORR_W   = 16;
	localparam int STRIP_W  = 16;
	localparam int SHIFT_W  = 5;
	localparam int THR_W    = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int TADDR_W  = 14;

	// strip sum limit; sums at or below 73 set the k bit of the table address
	localparam logic [STRIP_W-1:0] STRIP_SUM_HI = 16'd74;
	localparam int V_SHIFT = 6;
	localparam int K_BIT   = 12;

	localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd16;

	typedef enum logic [1:0] {
		FUNC_HIT  = 2'd0,
		FUNC_WR_U = 2'd1,
		FUNC_WR_V = 2'd2,
		FUNC_WR_W = 2'd3
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HIT_THRESHOLD = 1'd0,
		REG_RESULT_SHIFT  = 1'd1
	} reg_idx_t;

	typedef struct packed {
		logic valid;
		logic hit;
		logic nz;
	} stage_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/cac_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none

module cac_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 16384,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

/* hw/rtl/cac_front.sv */
// Strip numbers and table address: raw address in stage 1, reduced modulo depth in stage 2.
// Depends on cac_pkg.
`default_nettype none

module cac_front #(
	parameter int TABLE_DEPTH = 16384,
	parameter int COORD_BITS  = 10,
	localparam int AW = $clog2(TABLE_DEPTH)
) (
	input  wire logic                        clk,
	input  wire logic                        load,
	input  wire logic                        is_hit,
	input  wire logic [COORD_BITS-1:0]       coord_u,
	input  wire logic [COORD_BITS-1:0]       coord_v,
	input  wire logic [COORD_BITS-1:0]       coord_w,
	input  wire logic [cac_pkg::TADDR_W-1:0] table_addr,
	output logic      [AW-1:0]               addr_s2
);

	localparam int RW = 19;
	localparam logic [RW-1:0] D1 = RW'(TABLE_DEPTH);
	localparam logic [RW-1:0] D2 = RW'(2 * TABLE_DEPTH);
	localparam logic [RW-1:0] D4 = RW'(4 * TABLE_DEPTH);

	logic [cac_pkg::STRIP_W-1:0] su, sv, sw, ssum;
	logic                        kk;
	logic [15:0]                 raw, raw_s1;
	logic [RW-1:0]               r0, r1, r2, r3;

	always_comb begin
		su   = cac_pkg::STRIP_W'(coord_u[COORD_BITS-1:3]) + 16'd1;
		sv   = cac_pkg::STRIP_W'(coord_v[COORD_BITS-1:3]) + 16'd1;
		sw   = cac_pkg::STRIP_W'(coord_w[COORD_BITS-1:3]) + 16'd1;
		ssum = su + sv + sw;
		// a strip sum below STRIP_SUM_HI (74) sets the k bit
		kk   = (ssum < cac_pkg::STRIP_SUM_HI);
		if (is_hit) begin
			raw = su | (sv << cac_pkg::V_SHIFT) | (16'(kk) << cac_pkg::K_BIT);
		end else begin
			raw = 16'(table_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			raw_s1 <= raw;
		end
	end

	// value below 2^16 and depth at least 2^13: three compare-subtract steps
	always_comb begin
		r0 = RW'(raw_s1);
		r1 = (r0 >= D4) ? r0 - D4 : r0;
		r2 = (r1 >= D2) ? r1 - D2 : r1;
		r3 = (r2 >= D1) ? r2 - D1 : r2;
	end

	always_ff @(posedge clk) begin
		addr_s2 <= r3[AW-1:0];
	end

endmodule

`default_nettype wire

/* hw/rtl/cac_lane.sv */
// One view lane: energy x fraction, attenuation table lookup, product and shift.
// Depends on cac_pkg and cac_ram.
`default_nettype none

module cac_lane #(
	parameter int TABLE_DEPTH = 16384,
	localparam int AW = $clog2(TABLE_DEPTH)
) (
	input  wire logic                         clk,
	input  wire logic [cac_pkg::ENERGY_W-1:0] energy_s1,
	input  wire logic [cac_pkg::FRAC_W-1:0]   frac_s1,
	input  wire logic                         ram_we,
	input  wire logic [AW-1:0]                ram_addr,
	input  wire logic [cac_pkg::ATTEN_W-1:0]  ram_wdata,
	input  wire logic [cac_pkg::SHIFT_W-1:0]  shift,
	output logic      [cac_pkg::CORR_W-1:0]   corr_s5
);

	logic [cac_pkg::PROD_W-1:0]  prod_s2, prod_s3, p_s4;
	logic [cac_pkg::ATTEN_W-1:0] atten_s3;
	logic [40:0]                 p_full;
	logic [cac_pkg::PROD_W-1:0]  p_shr;

	cac_ram #(
		.WIDTH(cac_pkg::ATTEN_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(atten_s3)
	);

	always_comb begin
		p_full = 41'(prod_s3) * 41'(atten_s3);
		p_shr  = p_s4 >> shift;
	end

	always_ff @(posedge clk) begin
		prod_s2 <= cac_pkg::PROD_W'(energy_s1) * cac_pkg::PROD_W'(frac_s1);
		prod_s3 <= prod_s2;
		p_s4    <= p_full[cac_pkg::PROD_W-1:0];
		corr_s5 <= p_shr[cac_pkg::CORR_W-1:0];
	end

endmodule

`default_nettype wire

/* hw/rtl/cac_merge.sv */
// Merge stage: sums the three lane results, applies threshold and zero-energy rule.
// Depends on cac_pkg.
`default_nettype none

module cac_merge (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire cac_pkg::stage_ctl_t        ctl_s5,
	input  wire logic [cac_pkg::CORR_W-1:0] corr_u_s5,
	input  wire logic [cac_pkg::CORR_W-1:0] corr_v_s5,
	input  wire logic [cac_pkg::CORR_W-1:0] corr_w_s5,
	input  wire logic [cac_pkg::THR_W-1:0]  threshold,
	output logic                            done_q,
	output logic      [cac_pkg::CORR_W-1:0] corr_u_q,
	output logic      [cac_pkg::CORR_W-1:0] corr_v_q,
	output logic      [cac_pkg::CORR_W-1:0] corr_w_q
);

	logic [cac_pkg::CORR_W-1:0] hsum;
	logic                       keep;

	always_comb begin
		hsum = corr_u_s5 + corr_v_s5 + corr_w_s5;
		keep = ctl_s5.nz && (hsum >= threshold);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_s5.valid && ctl_s5.hit;
		end
	end

	always_ff @(posedge clk) begin
		corr_u_q <= keep ? corr_u_s5 : '0;
		corr_v_q <= keep ? corr_v_s5 : '0;
		corr_w_q <= keep ? corr_w_s5 : '0;
	end

endmodule

`default_nettype wire

/* hw/rtl/calorimeter_attenuation_correction.sv */
// Top level of the calorimeter attenuation correction block.
// Depends on cac_pkg, cac_front, cac_lane, cac_merge, cac_ram.
//
// Usage:
//   Input beats are taken at a clock edge with start high and busy low. A beat
//   with func = hit produces one result; a table-write beat (u, v or w) writes
//   one attenuation word and produces no result.
//   A result appears on corrected_u/v/w with done high for exactly one cycle,
//   once the beat has passed stages s1 to s5 and the merge output register;
//   results keep input order. The receiver cannot stall, so nothing ever
//   backs up.
//   Throughput is one beat per cycle while busy is low: a three-lane pipeline,
//   one table RAM per lane, each RAM used by one beat per cycle on a single
//   port. A table write is seen by any hit taken in a later cycle.
//   Reset: registers take their reset values, then a clearing pass zeroes all
//   TABLE_DEPTH entries (16384 by default) of the three tables one entry per
//   cycle; busy is high during the pass. Configuration writes (cfg_we, cfg_idx,
//   cfg_data) take effect at once and are to be made while no hit is in flight.
`default_nettype none

module calorimeter_attenuation_correction #(
	parameter int TABLE_DEPTH = 16384,
	parameter int COORD_BITS  = 10
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [1:0]                     func,
	input  wire logic [cac_pkg::ENERGY_W-1:0]   energy_u,
	input  wire logic [cac_pkg::ENERGY_W-1:0]   energy_v,
	input  wire logic [cac_pkg::ENERGY_W-1:0]   energy_w,
	input  wire logic [COORD_BITS-1:0]          coord_u,
	input  wire logic [COORD_BITS-1:0]          coord_v,
	input  wire logic [COORD_BITS-1:0]          coord_w,
	input  wire logic [cac_pkg::FRAC_W-1:0]     frac_u,
	input  wire logic [cac_pkg::FRAC_W-1:0]     frac_v,
	input  wire logic [cac_pkg::FRAC_W-1:0]     frac_w,
	input  wire logic [cac_pkg::TADDR_W-1:0]    table_addr,
	input  wire logic [cac_pkg::ATTEN_W-1:0]    table_value,
	input  wire logic                           cfg_we,
	input  wire logic [cac_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [cac_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                                done,
	output logic      [cac_pkg::CORR_W-1:0]     corrected_u,
	output logic      [cac_pkg::CORR_W-1:0]     corrected_v,
	output logic      [cac_pkg::CORR_W-1:0]     corrected_w
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam logic [AW-1:0] LAST_ENTRY = AW'(TABLE_DEPTH - 1);

	logic                         accept;
	logic                         clr_q;
	logic [AW-1:0]                clr_addr_q;
	logic [cac_pkg::THR_W-1:0]    thr_q;
	logic [cac_pkg::SHIFT_W-1:0]  shift_q;

	cac_pkg::stage_ctl_t          ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	cac_pkg::func_t               func_s1, func_s2;
	logic [cac_pkg::ATTEN_W-1:0]  value_s1, value_s2;
	logic [cac_pkg::ENERGY_W-1:0] eu_s1, ev_s1, ew_s1;
	logic [cac_pkg::FRAC_W-1:0]   fu_s1, fv_s1, fw_s1;
	logic [AW-1:0]                addr_s2, ram_addr;
	logic [cac_pkg::ATTEN_W-1:0]  ram_wdata;
	logic                         we_u, we_v, we_w;
	logic [cac_pkg::CORR_W-1:0]   corr_u_s5, corr_v_s5, corr_w_s5;

	assign busy   = clr_q;
	assign accept = start && !clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == LAST_ENTRY) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= '0;
			shift_q <= cac_pkg::SHIFT_RESET;
		end else if (cfg_we) begin
			unique case (cac_pkg::reg_idx_t'(cfg_idx))
				cac_pkg::REG_HIT_THRESHOLD: thr_q   <= cfg_data[cac_pkg::THR_W-1:0];
				cac_pkg::REG_RESULT_SHIFT:  shift_q <= cfg_data[cac_pkg::SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else begin
			ctl_s1.valid <= accept;
			ctl_s1.hit   <= (cac_pkg::func_t'(func) == cac_pkg::FUNC_HIT);
			ctl_s1.nz    <= (energy_u != '0) && (energy_v != '0) && (energy_w != '0);
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1  <= cac_pkg::func_t'(func);
			value_s1 <= table_value;
			eu_s1    <= energy_u;
			ev_s1    <= energy_v;
			ew_s1    <= energy_w;
			fu_s1    <= frac_u;
			fv_s1    <= frac_v;
			fw_s1    <= frac_w;
		end
		func_s2  <= func_s1;
		value_s2 <= value_s1;
	end

	cac_front #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk       (clk),
		.load      (accept),
		.is_hit    (cac_pkg::func_t'(func) == cac_pkg::FUNC_HIT),
		.coord_u   (coord_u),
		.coord_v   (coord_v),
		.coord_w   (coord_w),
		.table_addr(table_addr),
		.addr_s2   (addr_s2)
	);

	always_comb begin
		if (clr_q) begin
			ram_addr  = clr_addr_q;
			ram_wdata = '0;
			we_u      = 1'b1;
			we_v      = 1'b1;
			we_w      = 1'b1;
		end else begin
			ram_addr  = addr_s2;
			ram_wdata = value_s2;
			we_u      = ctl_s2.valid && (func_s2 == cac_pkg::FUNC_WR_U);
			we_v      = ctl_s2.valid && (func_s2 == cac_pkg::FUNC_WR_V);
			we_w      = ctl_s2.valid && (func_s2 == cac_pkg::FUNC_WR_W);
		end
	end

	cac_lane #(.TABLE_DEPTH(TABLE_DEPTH)) u_lane_u (
		.clk      (clk),
		.energy_s1(eu_s1),
		.frac_s1  (fu_s1),
		.ram_we   (we_u),
		.ram_addr (ram_addr),
		.ram_wdata(ram_wdata),
		.shift    (shift_q),
		.corr_s5  (corr_u_s5)
	);

	cac_lane #(.TABLE_DEPTH(TABLE_DEPTH)) u_lane_v (
		.clk      (clk),
		.energy_s1(ev_s1),
		.frac_s1  (fv_s1),
		.ram_we   (we_v),
		.ram_addr (ram_addr),
		.ram_wdata(ram_wdata),
		.shift    (shift_q),
		.corr_s5  (corr_v_s5)
	);

	cac_lane #(.TABLE_DEPTH(TABLE_DEPTH)) u_lane_w (
		.clk      (clk),
		.energy_s1(ew_s1),
		.frac_s1  (fw_s1),
		.ram_we   (we_w),
		.ram_addr (ram_addr),
		.ram_wdata(ram_wdata),
		.shift    (shift_q),
		.corr_s5  (corr_w_s5)
	);

	cac_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_s5   (ctl_s5),
		.corr_u_s5(corr_u_s5),
		.corr_v_s5(corr_v_s5),
		.corr_w_s5(corr_w_s5),
		.threshold(thr_q),
		.done_q   (done),
		.corr_u_q (corrected_u),
		.corr_v_q (corrected_v),
		.corr_w_q (corrected_w)
	);

endmodule

`default_nettype wire

/* sim/calorimeter_attenuation_correction_test.sv */
// Self-checking testbench for calorimeter_attenuation_correction: a scoreboard class predicts
// the corrected energies of every hit beat, and plain tasks drive beats and register writes.
// Depends on cac_pkg and the calorimeter_attenuation_correction RTL.
module calorimeter_attenuation_correction_test;
	import cac_pkg::*;

	localparam int TABLE_DEPTH  = 16384;
	localparam int COORD_BITS   = 10;
	localparam int STRIP_SUM_LO = 73;
	localparam int ITEM_TARGET  = 950;
	localparam int PHASES       = 5;
	localparam int DRAIN_CYCLES = 10;
	localparam int CYCLE_LIMIT  = 150000;

	typedef struct packed {
		func_t                 func;
		logic [ENERGY_W-1:0]   energy_u;
		logic [ENERGY_W-1:0]   energy_v;
		logic [ENERGY_W-1:0]   energy_w;
		logic [COORD_BITS-1:0] coord_u;
		logic [COORD_BITS-1:0] coord_v;
		logic [COORD_BITS-1:0] coord_w;
		logic [FRAC_W-1:0]     frac_u;
		logic [FRAC_W-1:0]     frac_v;
		logic [FRAC_W-1:0]     frac_w;
		logic [TADDR_W-1:0]    table_addr;
		logic [ATTEN_W-1:0]    table_value;
	} beat_t;

	typedef struct packed {
		logic [CORR_W-1:0] u;
		logic [CORR_W-1:0] v;
		logic [CORR_W-1:0] w;
	} corr_t;

	class atten_scoreboard;
		bit [ATTEN_W-1:0] u_table[TABLE_DEPTH];
		bit [ATTEN_W-1:0] v_table[TABLE_DEPTH];
		bit [ATTEN_W-1:0] w_table[TABLE_DEPTH];
		bit [THR_W-1:0]   threshold;
		bit [SHIFT_W-1:0] shift;
		corr_t            expected_hits[$];
		int unsigned      errors;

		function new();
			threshold = '0;
			shift = SHIFT_RESET;
			errors = 0;
		endfunction

		function void write_register(reg_idx_t idx, bit [CFG_DATA_W-1:0] data);
			case (idx)
				REG_HIT_THRESHOLD: threshold = data[THR_W-1:0];
				REG_RESULT_SHIFT:  shift = data[SHIFT_W-1:0];
				default: ;
			endcase
		endfunction

		function bit [31:0] table_index(bit [COORD_BITS-1:0] cu, bit [COORD_BITS-1:0] cv,
				bit [COORD_BITS-1:0] cw);
			bit [STRIP_W-1:0] su, sv, sw, total, kk;
			bit [31:0] a;
			su = STRIP_W'(cu >> 3) + 16'd1;
			sv = STRIP_W'(cv >> 3) + 16'd1;
			sw = STRIP_W'(cw >> 3) + 16'd1;
			total = su + sv + sw;
			if (total < STRIP_SUM_LO)
				sw = 16'(STRIP_SUM_LO) - 16'(su + sv);
			else if (total > STRIP_SUM_HI)
				sw = STRIP_SUM_HI - 16'(su + sv);
			total = su + sv + sw;
			kk = STRIP_SUM_HI - total;
			a = {16'd0, su} | ({16'd0, sv} << V_SHIFT) | ({16'd0, kk} << K_BIT);
			a = a & 32'h0000_FFFF;
			return a % TABLE_DEPTH;
		endfunction

		function bit [CORR_W-1:0] scaled(bit [15:0] e, bit [15:0] f, bit [ATTEN_W-1:0] att);
			bit [PROD_W-1:0] p;
			p = {16'd0, e} * {16'd0, f};
			p = p * {23'd0, att};
			return CORR_W'(p >> shift);
		endfunction

		function void note_beat(beat_t b);
			corr_t c;
			bit [31:0] a;
			bit [CORR_W-1:0] hsum;
			c = '0;
			case (b.func)
				FUNC_WR_U: u_table[b.table_addr % TABLE_DEPTH] = b.table_value;
				FUNC_WR_V: v_table[b.table_addr % TABLE_DEPTH] = b.table_value;
				FUNC_WR_W: w_table[b.table_addr % TABLE_DEPTH] = b.table_value;
				default: begin
					if (b.energy_u != 0 && b.energy_v != 0 && b.energy_w != 0) begin
						a = table_index(b.coord_u, b.coord_v, b.coord_w);
						c.u = scaled(b.energy_u, b.frac_u, u_table[a]);
						c.v = scaled(b.energy_v, b.frac_v, v_table[a]);
						c.w = scaled(b.energy_w, b.frac_w, w_table[a]);
						hsum = c.u + c.v + c.w;
						if (hsum < threshold)
							c = '0;
					end
					expected_hits.push_back(c);
				end
			endcase
		endfunction

		function void check_corrected(corr_t got);
			corr_t want;
			if (expected_hits.size() == 0) begin
				$error("result with nothing expected: u %0d v %0d w %0d", got.u, got.v, got.w);
				errors++;
				return;
			end
			want = expected_hits.pop_front();
			if (got.u !== want.u) begin
				$error("corrected_u: expected %0d, actual %0d", want.u, got.u);
				errors++;
			end
			if (got.v !== want.v) begin
				$error("corrected_v: expected %0d, actual %0d", want.v, got.v);
				errors++;
			end
			if (got.w !== want.w) begin
				$error("corrected_w: expected %0d, actual %0d", want.w, got.w);
				errors++;
			end
		endfunction

		function int pending();
			return expected_hits.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] func;
	logic [ENERGY_W-1:0] energy_u, energy_v, energy_w;
	logic [COORD_BITS-1:0] coord_u, coord_v, coord_w;
	logic [FRAC_W-1:0] frac_u, frac_v, frac_w;
	logic [TADDR_W-1:0] table_addr;
	logic [ATTEN_W-1:0] table_value;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic done;
	logic [CORR_W-1:0] corrected_u, corrected_v, corrected_w;

	atten_scoreboard sb;
	beat_t taken;
	beat_t seen;
	int unsigned cycles;
	int unsigned items_sent;
	bit no_gaps;

	calorimeter_attenuation_correction #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.COORD_BITS (COORD_BITS)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.energy_u   (energy_u),
		.energy_v   (energy_v),
		.energy_w   (energy_w),
		.coord_u    (coord_u),
		.coord_v    (coord_v),
		.coord_w    (coord_w),
		.frac_u     (frac_u),
		.frac_v     (frac_v),
		.frac_w     (frac_w),
		.table_addr (table_addr),
		.table_value(table_value),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.done       (done),
		.corrected_u(corrected_u),
		.corrected_v(corrected_v),
		.corrected_w(corrected_w)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Everything read here holds its pre-edge value.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.write_register(reg_idx_t'(cfg_idx), cfg_data);
			if (start && !busy) begin
				seen.func = func_t'(func);
				seen.energy_u = energy_u;
				seen.energy_v = energy_v;
				seen.energy_w = energy_w;
				seen.coord_u = coord_u;
				seen.coord_v = coord_v;
				seen.coord_w = coord_w;
				seen.frac_u = frac_u;
				seen.frac_v = frac_v;
				seen.frac_w = frac_w;
				seen.table_addr = table_addr;
				seen.table_value = table_value;
				sb.note_beat(seen);
			end
			if (done)
				sb.check_corrected('{u: corrected_u, v: corrected_v, w: corrected_w});
		end
	end

	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 15))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(1, 255));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [ATTEN_W-1:0] pick_atten();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return ATTEN_W'($urandom);
		endcase
	endfunction

	function automatic beat_t random_beat(func_t f);
		beat_t b;
		b.func = f;
		b.energy_u = pick_word();
		b.energy_v = pick_word();
		b.energy_w = pick_word();
		b.coord_u = COORD_BITS'($urandom);
		b.coord_v = COORD_BITS'($urandom);
		b.coord_w = COORD_BITS'($urandom);
		b.frac_u = pick_word();
		b.frac_v = pick_word();
		b.frac_w = pick_word();
		b.table_addr = TADDR_W'($urandom);
		b.table_value = pick_atten();
		return b;
	endfunction

	function automatic beat_t hit_at(logic [COORD_BITS-1:0] cu, logic [COORD_BITS-1:0] cv,
			logic [COORD_BITS-1:0] cw, logic [15:0] e, logic [15:0] f);
		beat_t b;
		b = random_beat(FUNC_HIT);
		b.coord_u = cu;
		b.coord_v = cv;
		b.coord_w = cw;
		b.energy_u = e;
		b.energy_v = e;
		b.energy_w = e;
		b.frac_u = f;
		b.frac_v = f;
		b.frac_w = f;
		return b;
	endfunction

	task automatic send_beat(beat_t b);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 11);
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		func <= b.func;
		energy_u <= b.energy_u;
		energy_v <= b.energy_v;
		energy_w <= b.energy_w;
		coord_u <= b.coord_u;
		coord_v <= b.coord_v;
		coord_w <= b.coord_w;
		frac_u <= b.frac_u;
		frac_v <= b.frac_v;
		frac_w <= b.frac_w;
		table_addr <= b.table_addr;
		table_value <= b.table_value;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		items_sent++;
	endtask

	task automatic load_entry(logic [TADDR_W-1:0] a, logic [ATTEN_W-1:0] vu,
			logic [ATTEN_W-1:0] vv, logic [ATTEN_W-1:0] vw);
		beat_t b;
		b = random_beat(FUNC_WR_U);
		b.table_addr = a;
		b.table_value = vu;
		send_beat(b);
		b.func = FUNC_WR_V;
		b.table_value = vv;
		send_beat(b);
		b.func = FUNC_WR_W;
		b.table_value = vw;
		send_beat(b);
	endtask

	// Registers change only with no hit in flight.
	task automatic write_registers(logic [THR_W-1:0] thr, logic [SHIFT_W-1:0] sh);
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= REG_HIT_THRESHOLD;
		cfg_data <= CFG_DATA_W'(thr);
		@(negedge clk);
		cfg_idx <= REG_RESULT_SHIFT;
		cfg_data <= CFG_DATA_W'(sh);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Optional table load for one strip triple, then hits on it; w strip sometimes lands on the valid sum.
	task automatic run_sequence();
		logic [COORD_BITS-1:0] cu, cv, cw;
		int target;
		int hits;
		beat_t b;
		cu = COORD_BITS'($urandom);
		cv = COORD_BITS'($urandom);
		cw = COORD_BITS'($urandom);
		if ($urandom_range(0, 1) == 1) begin
			target = ($urandom_range(0, 1) ? STRIP_SUM_LO : int'(STRIP_SUM_HI))
				- int'(cu >> 3) - int'(cv >> 3) - 2;
			if (target >= 1 && target <= (1 << (COORD_BITS - 3)))
				cw = COORD_BITS'(((target - 1) << 3) | $urandom_range(0, 7));
		end
		if ($urandom_range(0, 3) != 0)
			load_entry(TADDR_W'(sb.table_index(cu, cv, cw)), pick_atten(), pick_atten(),
				pick_atten());
		hits = $urandom_range(1, 4);
		repeat (hits) begin
			b = random_beat(FUNC_HIT);
			b.coord_u = {cu[COORD_BITS-1:3], 3'($urandom)};
			b.coord_v = {cv[COORD_BITS-1:3], 3'($urandom)};
			b.coord_w = {cw[COORD_BITS-1:3], 3'($urandom)};
			send_beat(b);
		end
	endtask

	initial begin
		logic [THR_W-1:0] thr;
		logic [SHIFT_W-1:0] sh;
		int phase_end;
		sb = new();
		cycles = 0;
		items_sent = 0;
		no_gaps = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		func = FUNC_HIT;
		energy_u = '0;
		energy_v = '0;
		energy_w = '0;
		coord_u = '0;
		coord_v = '0;
		coord_w = '0;
		frac_u = '0;
		frac_v = '0;
		frac_w = '0;
		table_addr = '0;
		table_value = '0;
		cfg_we = 1'b0;
		cfg_idx = REG_HIT_THRESHOLD;
		cfg_data = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		write_registers(16'd0, SHIFT_RESET);

		// directed: cleared tables, table extremes, zero energy per view, strip sum cases
		send_beat(hit_at('0, '0, '0, 16'hFFFF, 16'hFFFF));
		load_entry(TADDR_W'(sb.table_index('0, '0, '0)), '1, '1, '1);
		send_beat(hit_at('0, '0, '0, 16'hFFFF, 16'hFFFF));
		send_beat(hit_at('0, '0, '0, 16'd1, 16'd1));
		load_entry(TADDR_W'(sb.table_index('1, '1, '1)), 9'd3, 9'd255, 9'd1);
		send_beat(hit_at('1, '1, '1, 16'd1234, 16'd40000));
		load_entry(TADDR_W'(sb.table_index('0, '0, 10'd560)), 9'd100, 9'd200, 9'd300);
		send_beat(hit_at('0, '0, 10'd560, 16'd5000, 16'd7000));
		load_entry(TADDR_W'(sb.table_index('0, '0, 10'd568)), 9'd7, 9'd8, 9'd9);
		send_beat(hit_at('0, '0, 10'd568, 16'd5000, 16'd7000));
		taken = hit_at('0, '0, '0, 16'hFFFF, 16'hFFFF);
		taken.energy_u = '0;
		send_beat(taken);
		taken.energy_u = 16'hFFFF;
		taken.energy_v = '0;
		send_beat(taken);
		taken.energy_v = 16'hFFFF;
		taken.energy_w = '0;
		send_beat(taken);
		load_entry('1, '0, '1, '0);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin thr = 16'd0; sh = SHIFT_RESET; end
				1: begin thr = 16'hFFFF; sh = 5'd0; end
				2: begin thr = THR_W'($urandom_range(0, 2)); sh = 5'd31; end
				3: begin thr = THR_W'($urandom); sh = SHIFT_W'($urandom); end
				default: begin thr = 16'd1; sh = SHIFT_W'($urandom_range(8, 20)); end
			endcase
			write_registers(thr, sh);
			phase_end = (ITEM_TARGET * (p + 1)) / PHASES;
			while (items_sent < phase_end) begin
				no_gaps = ($urandom_range(0, 4) == 0);
				if ($urandom_range(0, 9) < 7)
					run_sequence();
				else
					send_beat(random_beat(func_t'($urandom_range(0, 3))));
			end
		end

		@(negedge clk);
		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
